// ===== rtl/timestamped_event_release_queue_defines.svh =====
// assertion macros for the event release queue
`ifndef TIMESTAMPED_EVENT_RELEASE_QUEUE_DEFINES_SVH
`define TIMESTAMPED_EVENT_RELEASE_QUEUE_DEFINES_SVH

// clocked property with reset disable
`define TSERQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression that must never hold
`define TSERQ_NEVER(label, expr, msg) \
	`TSERQ_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/tserq_pkg.sv =====
// types and constants of the event release queue
package tserq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 32;
	localparam int MAX_RELEASE = 32;
	localparam int TW = 48;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_DUE      = 2'd2;
	localparam logic [1:0] ST_NONE     = 2'd3;

	localparam logic [1:0] REG_LOOKAHEAD  = 2'd0;
	localparam logic [1:0] REG_LOOP_EN    = 2'd1;
	localparam logic [1:0] REG_LOOP_START = 2'd2;
	localparam logic [1:0] REG_LOOP_END   = 2'd3;

	localparam logic REQ_SCHEDULE = 1'b0;
	localparam logic REQ_ADVANCE  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [47:0] event_time;
		logic [31:0] event_tag;
		logic [15:0] advance_samples;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [47:0] due_time;
		logic [31:0] due_tag;
		logic [47:0] position;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_END,
		S_SEL_RD,
		S_SEL_CHK,
		S_SEL_EMIT
	} state_t;

endpackage

// ===== rtl/tserq_ram.sv =====
// generic single write, single read ram with registered read
module tserq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;
endmodule

// ===== rtl/tserq_rem.sv =====
// bit-serial 48-bit remainder unit, one quotient bit per cycle
module tserq_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [47:0] divisor,
	output logic        done,
	output logic [47:0] rem
);
	import tserq_pkg::*;

	logic [48:0] r_q;
	logic [47:0] dvd_q;
	logic [47:0] d_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [48:0] trial;

	assign trial = {r_q[47:0], dvd_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(TW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= '0;
			dvd_q <= dividend;
			d_q   <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[46:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
			end else begin
				r_q <= trial;
			end
		end
	end

	assign done = done_q;
	assign rem  = r_q[47:0];
endmodule

// ===== rtl/timestamped_event_release_queue.sv =====
// event release queue: fifo of timestamped events and a looping sample position
// latency: a schedule beat gives its result in the next cycle, busy stays low
// advance: busy while the remainder unit runs (on a wrap with valid bounds)
// and while the single ram read port walks the queue, once to count and once per release
// results cannot be stalled: each result is one strobed cycle on res
// arst_n clears pointers, fill count, position and configuration; ram contents stay undefined
module timestamped_event_release_queue #(
	parameter int QUEUE_DEPTH = tserq_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tserq_pkg::req_t   req,
	output logic              res_valid,
	output tserq_pkg::res_t   res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [47:0]       cfg_data
);
	import tserq_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int LW = (CW > 6) ? CW : 6;
	localparam int EW = TW + 32;

	// configuration
	logic [17:0] look_q;
	logic        loop_en_q;
	logic [47:0] loop_start_q;
	logic [47:0] loop_end_q;

	// queue and position state
	state_t         state_q, state_d;
	logic [47:0]    pos_q;
	logic [AW-1:0]  head_q, tail_q, rp_q;
	logic [CW-1:0]  fill_q;
	logic [5:0]     n_q, k_q, e_q;
	logic [MAX_RELEASE-1:0] emitted_q;
	logic [47:0]    best_time_q;
	logic [31:0]    best_tag_q;
	logic [4:0]     best_k_q;
	logic           best_ok_q;
	res_t           res_q;
	logic           res_valid_q;

	// datapath
	logic [48:0]   tsum, psum;
	logic [47:0]   tsat, psat;
	logic          full, wrap, bounds_ok;
	logic          accept;
	logic [AW-1:0] rp_next;
	logic [EW-1:0] rd_data;
	logic [47:0]   rd_time;
	logic [31:0]   rd_tag;
	logic          wr_en;
	logic          rem_start, rem_done;
	logic [47:0]   rem;
	logic          more;
	logic          last_emit;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// saturating adds for event time and position
	assign tsum = {1'b0, req.event_time} + {31'd0, look_q};
	assign tsat = tsum[48] ? '1 : tsum[47:0];
	assign psum = {1'b0, pos_q} + {33'd0, req.advance_samples};
	assign psat = psum[48] ? '1 : psum[47:0];

	assign full      = (fill_q == CW'(QUEUE_DEPTH));
	assign wrap      = loop_en_q && (loop_end_q != '0) && (psat >= loop_end_q);
	assign bounds_ok = (loop_end_q > loop_start_q);

	assign rp_next = (rp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + AW'(1);
	assign rd_time = rd_data[EW-1:32];
	assign rd_tag  = rd_data[31:0];

	// still room to scan: entries left and release limit not reached
	assign more      = (LW'(fill_q) > LW'(n_q)) && (n_q < 6'(MAX_RELEASE));
	assign last_emit = ((e_q + 6'd1) == n_q);

	assign wr_en     = accept && (req.req_type == REQ_SCHEDULE) && !full;
	assign rem_start = accept && (req.req_type == REQ_ADVANCE) && wrap && bounds_ok;

	tserq_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data ({tsat, req.event_tag}),
		.rd_addr (rp_q),
		.rd_data (rd_data)
	);

	tserq_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (psat - loop_start_q),
		.divisor  (loop_end_q - loop_start_q),
		.done     (rem_done),
		.rem      (rem)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.req_type == REQ_ADVANCE) begin
					state_d = rem_start ? S_MOD : S_SCAN_RD;
				end
			end
			S_MOD: begin
				if (rem_done) begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD:  state_d = more ? S_SCAN_CHK : S_SCAN_END;
			S_SCAN_CHK: state_d = (rd_time <= pos_q) ? S_SCAN_RD : S_SCAN_END;
			S_SCAN_END: state_d = (n_q == '0) ? S_IDLE : S_SEL_RD;
			S_SEL_RD:   state_d = (k_q == n_q) ? S_SEL_EMIT : S_SEL_CHK;
			S_SEL_CHK:  state_d = S_SEL_RD;
			S_SEL_EMIT: state_d = last_emit ? S_IDLE : S_SEL_RD;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q       <= '0;
			loop_en_q    <= 1'b0;
			loop_start_q <= '0;
			loop_end_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOOKAHEAD:  look_q       <= cfg_data[17:0];
				REG_LOOP_EN:    loop_en_q    <= cfg_data[0];
				REG_LOOP_START: loop_start_q <= cfg_data;
				REG_LOOP_END:   loop_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state: pointers, counts, position, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			rp_q        <= '0;
			fill_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			e_q         <= '0;
			emitted_q   <= '0;
			best_ok_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && req.req_type == REQ_SCHEDULE) begin
						res_valid_q <= 1'b1;
						if (!full) begin
							tail_q <= (tail_q == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + AW'(1);
							fill_q <= fill_q + CW'(1);
						end
					end else if (accept) begin
						// wrap with bad bounds snaps to loop start
						if (wrap && !bounds_ok) begin
							pos_q <= loop_start_q;
						end else begin
							pos_q <= psat;
						end
						rp_q <= head_q;
						n_q  <= '0;
					end
				end
				S_MOD: begin
					if (rem_done) begin
						pos_q <= loop_start_q + rem;
					end
				end
				S_SCAN_CHK: begin
					if (rd_time <= pos_q) begin
						n_q  <= n_q + 6'd1;
						rp_q <= rp_next;
					end
				end
				S_SCAN_END: begin
					if (n_q == '0) begin
						res_valid_q <= 1'b1;
					end
					rp_q      <= head_q;
					k_q       <= '0;
					e_q       <= '0;
					emitted_q <= '0;
					best_ok_q <= 1'b0;
				end
				S_SEL_CHK: begin
					// strict less keeps the earliest arrival among equal times
					if (!emitted_q[k_q[4:0]] && (!best_ok_q || rd_time < best_time_q)) begin
						best_ok_q <= 1'b1;
					end
					k_q  <= k_q + 6'd1;
					rp_q <= rp_next;
				end
				S_SEL_EMIT: begin
					res_valid_q          <= 1'b1;
					emitted_q[best_k_q]  <= 1'b1;
					e_q                  <= e_q + 6'd1;
					best_ok_q            <= 1'b0;
					k_q                  <= '0;
					if (last_emit) begin
						// after a full pass the read pointer sits just past the prefix
						head_q <= rp_q;
						fill_q <= fill_q - CW'(n_q);
					end else begin
						rp_q <= head_q;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept && req.req_type == REQ_SCHEDULE) begin
					res_q.status   <= full ? ST_FULL : ST_ACCEPTED;
					res_q.due_time <= '0;
					res_q.due_tag  <= '0;
					res_q.position <= pos_q;
					res_q.last     <= 1'b1;
				end
			end
			S_SCAN_END: begin
				res_q.status   <= ST_NONE;
				res_q.due_time <= '0;
				res_q.due_tag  <= '0;
				res_q.position <= pos_q;
				res_q.last     <= 1'b1;
			end
			S_SEL_CHK: begin
				if (!emitted_q[k_q[4:0]] && (!best_ok_q || rd_time < best_time_q)) begin
					best_time_q <= rd_time;
					best_tag_q  <= rd_tag;
					best_k_q    <= k_q[4:0];
				end
			end
			S_SEL_EMIT: begin
				res_q.status   <= ST_DUE;
				res_q.due_time <= best_time_q;
				res_q.due_tag  <= best_tag_q;
				res_q.position <= pos_q;
				res_q.last     <= last_emit;
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`include "timestamped_event_release_queue_defines.svh"

	`TSERQ_ASSERT(a_fill_bound, fill_q <= CW'(QUEUE_DEPTH), "fill count above depth")
	`TSERQ_NEVER(a_rem_outside, rem_done && state_q != S_MOD, "remainder done outside wrap")
	`TSERQ_ASSERT(a_emit_bound, (state_q == S_SEL_EMIT) |-> (e_q < n_q && best_ok_q), "release beyond due count")
endmodule
